// ===== src/bmorph_pkg.sv =====
// bmorph_pkg: shared constants, register codes and the result record for the
// 3x3 binary morphology block. No dependencies; imported by every module in src.
package bmorph_pkg;

   localparam int CfgWidth         = 11;
   localparam int CsrIndexWidth    = 2;
   localparam int MaxWidthDefault  = 1024;
   localparam int MaxHeightDefault = 1024;
   localparam int WidthReset       = 640;
   localparam int HeightReset      = 480;
   localparam int CoordWidth       = 10;
   localparam int ReqDataWidth     = 8;
   localparam int RspDataWidth     = 24;
   localparam int LineTaps         = 2;   // upper and middle row bit per column
   localparam int RspDepth         = 4;
   localparam int RspCountWidth    = $clog2(RspDepth + 1);

   typedef enum logic [CsrIndexWidth-1:0] {
      REG_IMAGE_WIDTH    = 2'd0,
      REG_IMAGE_HEIGHT   = 2'd1,
      REG_OPERATION_MODE = 2'd2,
      REG_ELEMENT_SHAPE  = 2'd3
   } csr_index_type;

   localparam logic REQ_PIXEL      = 1'b0;
   localparam logic REQ_FLUSH      = 1'b1;
   localparam logic MODE_DILATION  = 1'b0;
   localparam logic MODE_EROSION   = 1'b1;
   localparam logic SHAPE_CROSS    = 1'b0;
   localparam logic SHAPE_SQUARE   = 1'b1;

   typedef struct packed {
      logic                  frame_last;
      logic [CoordWidth-1:0] out_column;
      logic [CoordWidth-1:0] out_row;
      logic                  pixel_out;
   } rsp_type;

endpackage

// ===== src/bmorph_linebuf.sv =====
// bmorph_linebuf: one synchronous memory holding the two buffered rows per column,
// registered read, with same-edge write forwarding. Uses bmorph_pkg.
module bmorph_linebuf #(
   parameter int DEPTH = bmorph_pkg::MaxWidthDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rd_en,
   input  logic [$clog2(DEPTH)-1:0]             rd_addr,
   output logic [bmorph_pkg::LineTaps-1:0]      rd_data,
   input  logic                                 wr_en,
   input  logic [$clog2(DEPTH)-1:0]             wr_addr,
   input  logic [bmorph_pkg::LineTaps-1:0]      wr_data
);
   import bmorph_pkg::*;

   logic [LineTaps-1:0] line_mem [DEPTH];
   logic [LineTaps-1:0] rd_q_ff;
   logic [LineTaps-1:0] fwd_data_ff;
   logic                fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= line_mem[rd_addr];
      end
      fwd_data_ff <= wr_data;
   end

   // read and write of the same column on one edge: the read saw old data
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= rd_en && wr_en && (rd_addr == wr_addr);
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_q_ff;

endmodule

// ===== src/bmorph_rsp_fifo.sv =====
// bmorph_rsp_fifo: small result queue between the window stage and the rsp port.
// Uses bmorph_pkg::rsp_type.
module bmorph_rsp_fifo #(
   parameter int DEPTH = bmorph_pkg::RspDepth
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push_en,
   input  bmorph_pkg::rsp_type            push_data,
   output logic                           out_valid,
   input  logic                           out_ready,
   output bmorph_pkg::rsp_type            out_data,
   output logic [$clog2(DEPTH+1)-1:0]     count
);
   import bmorph_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rsp_type         entry_mem [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            pop;

   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_data  = entry_mem[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      count_in = count_ff + CW'(push_en) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         entry_mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/binary_morphology_3x3_top.sv =====
// binary_morphology_3x3_top: 3x3 binary dilation/erosion over a raster pixel stream.
// Result path: a transaction completing a neighborhood passes the line-buffer read
//   stage, then the result queue. Throughput: one transaction per cycle unless missing
//   queue credit or an extra drain push drops req_tready; a drain flush in a one-row
//   image walks two positions through the single line-buffer read/write port pair.
// Reset: clears position, pending count, window, queue and registers (640x480,
//   dilation, square). Line buffers are not cleared; unwritten columns are masked.
module binary_morphology_3x3_top #(
   parameter int MAX_WIDTH  = bmorph_pkg::MaxWidthDefault,
   parameter int MAX_HEIGHT = bmorph_pkg::MaxHeightDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [bmorph_pkg::ReqDataWidth-1:0]   req_tdata,  // [0] pixel_in, [7:1] zero
   input  logic                                  req_tuser,  // [0] req_type
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bmorph_pkg::RspDataWidth-1:0]   rsp_tdata,  // [0] pixel_out,
                                                             // [10:1] out_row,
                                                             // [20:11] out_column,
                                                             // [23:21] zero
   output logic                                  rsp_tlast,  // frame_last
   // register writes
   input  logic                                  csr_we,
   input  logic [bmorph_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [bmorph_pkg::CfgWidth-1:0]       csr_wdata
);
   import bmorph_pkg::*;

   // widths derived from the geometry limits
   localparam int CW   = $clog2(MAX_WIDTH);        // column address
   localparam int WDW  = $clog2(MAX_WIDTH + 1);    // holds the width itself
   localparam int HDW  = $clog2(MAX_HEIGHT + 1);   // holds the height itself
   localparam int RW   = $clog2(MAX_HEIGHT + 3);   // row runs two past the image in drain
   localparam int PW   = $clog2(MAX_WIDTH + 2);    // at most one row plus one pending
   localparam int OccW = RspCountWidth + 1;
   localparam int WinBits = 9;

   localparam int WidthInit  = (WidthReset  > MAX_WIDTH)  ? MAX_WIDTH  : WidthReset;
   localparam int HeightInit = (HeightReset > MAX_HEIGHT) ? MAX_HEIGHT : HeightReset;

   // window bit k = column (k/3), row (k%3); column 0 is the left one
   localparam logic [WinBits-1:0] ElemSquare = 9'b111_111_111;
   localparam logic [WinBits-1:0] ElemCross  = 9'b010_111_010;

   // ---------------------------------------------------------------- registers
   logic [WDW-1:0] width_ff;
   logic [HDW-1:0] height_ff;
   logic           mode_ff;
   logic           shape_ff;
   logic [WDW-1:0] width_wr;
   logic [HDW-1:0] height_wr;
   logic           wr_width, wr_height, wr_mode, wr_shape, geom_write;

   always_comb begin
      wr_width  = 1'b0;
      wr_height = 1'b0;
      wr_mode   = 1'b0;
      wr_shape  = 1'b0;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_IMAGE_WIDTH:    wr_width  = 1'b1;
            REG_IMAGE_HEIGHT:   wr_height = 1'b1;
            REG_OPERATION_MODE: wr_mode   = 1'b1;
            REG_ELEMENT_SHAPE:  wr_shape  = 1'b1;
            default: ;
         endcase
      end
      geom_write = wr_width || wr_height;

      // geometry is clamped to 1..MAX on the way in
      if (csr_wdata == '0) begin
         width_wr  = WDW'(1);
         height_wr = HDW'(1);
      end else begin
         width_wr  = (32'(csr_wdata) > 32'(MAX_WIDTH))  ? WDW'(MAX_WIDTH)  : WDW'(csr_wdata);
         height_wr = (32'(csr_wdata) > 32'(MAX_HEIGHT)) ? HDW'(MAX_HEIGHT) : HDW'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WDW'(WidthInit);
         height_ff <= HDW'(HeightInit);
         mode_ff   <= MODE_DILATION;
         shape_ff  <= SHAPE_SQUARE;
      end else begin
         if (wr_width)  width_ff  <= width_wr;
         if (wr_height) height_ff <= height_wr;
         if (wr_mode)   mode_ff   <= csr_wdata[0];
         if (wr_shape)  shape_ff  <= csr_wdata[0];
      end
   end

   // ---------------------------------------------------------------- issue stage
   // Position counters live here; each push reads its column from the line buffer.
   logic [RW-1:0]  row_ff, row_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [PW-1:0]  pending_ff, pending_in;
   logic           second_ff, second_in;       // drain flush needs one more push

   logic [RW-1:0]  h_r, r, cr;
   logic [CW-1:0]  c, cc;
   logic [PW-1:0]  pend_base, pend_inc;
   logic [OccW-1:0] occ;
   logic           credit, req_hs, is_pixel, in_drain;
   logic           pixel_go, flush_go, push_go, restart, push_pix;
   logic           emit_end, emit_mid, made;
   logic           top_ok, bot_ok, left_ok, right_ok, last_px;

   logic [RspCountWidth-1:0] fifo_count;
   logic                     b_valid_ff, b_emit_ff;

   always_comb begin
      h_r = RW'(height_ff);

      // room for everything already headed into the result queue
      occ        = OccW'(fifo_count) + OccW'(b_valid_ff && b_emit_ff);
      credit     = occ < OccW'(RspDepth - 1);
      req_tready = credit && !second_ff;

      req_hs   = req_tvalid && req_tready;
      is_pixel = (req_tuser == REQ_PIXEL);
      in_drain = (row_ff >= h_r);
      pixel_go = req_hs && is_pixel;
      flush_go = req_hs && (req_tuser == REQ_FLUSH) && in_drain && (pending_ff != '0);
      push_go  = pixel_go || flush_go || (second_ff && credit);
      restart  = pixel_go && in_drain;           // new image after a finished one
      push_pix = pixel_go ? req_tdata[0] : 1'b1;

      r = restart ? '0 : row_ff;
      c = restart ? '0 : col_ff;

      // column 0 closes the row two up; any other column emits its left neighbor
      emit_end = (c == '0) && (r >= RW'(2)) && (r < h_r + RW'(2));
      emit_mid = (c != '0) && (r >= RW'(1)) && (r < h_r + RW'(1));
      made     = emit_end || emit_mid;

      if (emit_end) begin
         cr = r - RW'(2);
         cc = CW'(width_ff - WDW'(1));
      end else begin
         cr = r - RW'(1);
         cc = c - CW'(1);
      end

      top_ok   = (cr != '0);
      bot_ok   = (cr + RW'(1)) < h_r;
      left_ok  = (cc != '0);
      right_ok = (WDW'(cc) + WDW'(1)) < width_ff;
      last_px  = ((cr + RW'(1)) == h_r) && ((WDW'(cc) + WDW'(1)) == width_ff);

      if ((WDW'(c) + WDW'(1)) >= width_ff) begin
         col_in = '0;
         row_in = r + RW'(1);
      end else begin
         col_in = c + CW'(1);
         row_in = r;
      end

      pend_base  = restart ? '0 : pending_ff;
      pend_inc   = pend_base + PW'(pixel_go);
      pending_in = (made && (pend_inc != '0)) ? pend_inc - PW'(1) : pend_inc;

      second_in = push_go ? (flush_go && !made) : second_ff;
   end

   // ---------------------------------------------------------------- window stage regs
   logic           b_end_ff, b_restart_ff, b_pix_ff;
   logic           b_top_ok_ff, b_bot_ok_ff, b_left_ok_ff, b_right_ok_ff, b_last_ff;
   logic [CW-1:0]  b_addr_ff, b_col_ff;
   logic [RW-1:0]  b_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         col_ff     <= '0;
         pending_ff <= '0;
         second_ff  <= 1'b0;
         b_valid_ff <= 1'b0;
         b_emit_ff  <= 1'b0;
      end else begin
         b_valid_ff <= push_go;
         b_emit_ff  <= push_go && made;
         if (geom_write) begin
            row_ff     <= '0;
            col_ff     <= '0;
            pending_ff <= '0;
            second_ff  <= 1'b0;
         end else begin
            second_ff <= second_in;
            if (push_go) begin
               row_ff     <= row_in;
               col_ff     <= col_in;
               pending_ff <= pending_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      b_end_ff      <= emit_end;
      b_restart_ff  <= restart;
      b_pix_ff      <= push_pix;
      b_addr_ff     <= c;
      b_row_ff      <= cr;
      b_col_ff      <= cc;
      b_top_ok_ff   <= top_ok;
      b_bot_ok_ff   <= bot_ok;
      b_left_ok_ff  <= left_ok;
      b_right_ok_ff <= right_ok;
      b_last_ff     <= last_px;
   end

   // ---------------------------------------------------------------- line buffer
   // rd_data[1] = row two up, rd_data[0] = row one up; written back shifted by one row.
   logic [LineTaps-1:0] lb_rd;

   bmorph_linebuf #(
      .DEPTH (MAX_WIDTH)
   ) u_linebuf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (push_go),
      .rd_addr (c),
      .rd_data (lb_rd),
      .wr_en   (b_valid_ff),
      .wr_addr (b_addr_ff),
      .wr_data ({lb_rd[0], b_pix_ff})
   );

   // ---------------------------------------------------------------- window and result
   logic [WinBits-1:0] window_ff;
   logic [WinBits-1:0] win_old, win_new, win_sel, elem_mask, ok_mask, hit_vec, miss_vec;
   logic [2:0]         row_ok3;
   logic               pixel_res;
   rsp_type            res;

   always_comb begin
      win_old = b_restart_ff ? '1 : window_ff;
      win_new = {b_pix_ff, lb_rd[0], lb_rd[1], win_old[WinBits-1:3]};
      // column 0 result uses the window before the shift, right column off image
      win_sel = b_end_ff ? {3'b111, win_old[WinBits-1:3]} : win_new;

      elem_mask = (shape_ff == SHAPE_SQUARE) ? ElemSquare : ElemCross;
      row_ok3   = {b_bot_ok_ff, 1'b1, b_top_ok_ff};
      ok_mask   = {row_ok3 & {3{b_right_ok_ff}}, row_ok3, row_ok3 & {3{b_left_ok_ff}}};

      hit_vec  = elem_mask & ok_mask & ~win_sel;          // in-bounds foreground points
      miss_vec = elem_mask & ~(ok_mask & ~win_sel);       // points that break erosion

      if (mode_ff == MODE_DILATION) begin
         pixel_res = ~(|hit_vec);
      end else begin
         pixel_res = |miss_vec;
      end

      res.pixel_out  = pixel_res;
      res.out_row    = CoordWidth'(b_row_ff);
      res.out_column = CoordWidth'(b_col_ff);
      res.frame_last = b_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '1;
      end else if (geom_write) begin
         window_ff <= '1;
      end else if (b_valid_ff) begin
         window_ff <= win_new;
      end
   end

   // ---------------------------------------------------------------- result queue
   rsp_type fifo_out;

   bmorph_rsp_fifo #(
      .DEPTH (RspDepth)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (b_valid_ff && b_emit_ff),
      .push_data (res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (fifo_out),
      .count     (fifo_count)
   );

   assign rsp_tdata = RspDataWidth'({fifo_out.out_column, fifo_out.out_row,
                                     fifo_out.pixel_out});
   assign rsp_tlast = fifo_out.frame_last;

   // ---------------------------------------------------------------- checks
   // the issue credit must keep a slot free for every result in flight
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_emit_ff) |-> (fifo_count < RspCountWidth'(RspDepth)))
      else $error("result queue overrun");

   // an extra drain step only arises once the image rows are all in
   a_second_in_drain: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> (row_ff >= RW'(height_ff)))
      else $error("extra drain step outside drain");

   // every accepted pixel transaction walks through the line buffer
   a_pixel_pushed: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == REQ_PIXEL)) |=> b_valid_ff)
      else $error("accepted pixel not pushed");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench for binary_morphology_3x3_top. It drives pixel and
// flush transactions, predicts every result pixel and compares it field by field.
// Depends on bmorph_pkg and the RTL in src.

import bmorph_pkg::*;

// Line-buffer morphology predictor plus the queue of result pixels still owed.
class morph_scoreboard;
   bit                upper_buf [MaxWidthDefault];
   bit                middle_buf [MaxWidthDefault];
   bit [8:0]          window;        // three 3-bit columns, oldest in [2:0]
   int unsigned       row_pos;
   int unsigned       col_pos;
   int unsigned       pending;
   bit [CfgWidth-1:0] width_reg;
   bit [CfgWidth-1:0] height_reg;
   logic              mode_reg;
   logic              shape_reg;
   rsp_type           pixels_due [$];
   int                error_count;

   function new();
      width_reg   = CfgWidth'(WidthReset);
      height_reg  = CfgWidth'(HeightReset);
      mode_reg    = MODE_DILATION;
      shape_reg   = SHAPE_SQUARE;
      error_count = 0;
      restart();
   endfunction

   function void restart();
      window  = '1;
      row_pos = 0;
      col_pos = 0;
      pending = 0;
   endfunction

   // 0 acts as 1, anything above the maximum acts as the maximum
   function int unsigned eff_dim(bit [CfgWidth-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return 32'(v);
   endfunction

   function void write_reg(csr_index_type idx, bit [CfgWidth-1:0] val);
      case (idx)
         REG_IMAGE_WIDTH: begin
            width_reg = val;
            restart();
         end
         REG_IMAGE_HEIGHT: begin
            height_reg = val;
            restart();
         end
         REG_OPERATION_MODE: mode_reg = val[0];
         REG_ELEMENT_SHAPE:  shape_reg = val[0];
         default: ;
      endcase
   endfunction

   // One output pixel at (cr, cc); bit 0 of each column is the top row.
   function void morph_point(bit [2:0] lcol, bit [2:0] ccol, bit [2:0] rcol,
                             int unsigned cr, int unsigned cc);
      int unsigned w, h, zeros, points;
      bit [2:0]    col;
      bit          in_img;
      rsp_type     res;
      w      = eff_dim(width_reg, MaxWidthDefault);
      h      = eff_dim(height_reg, MaxHeightDefault);
      zeros  = 0;
      points = 0;
      for (int dr = 0; dr < 3; dr++) begin
         for (int dc = 0; dc < 3; dc++) begin
            if (shape_reg == SHAPE_CROSS && dr != 1 && dc != 1) continue;
            points++;
            col    = (dc == 0) ? lcol : (dc == 1) ? ccol : rcol;
            in_img = !((dr == 0 && cr < 1) || (dr == 2 && cr + 1 >= h) ||
                       (dc == 0 && cc < 1) || (dc == 2 && cc + 1 >= w));
            if (in_img && !col[dr]) zeros++;
         end
      end
      // erosion needs every point in bounds and zero, so edges give background
      res.pixel_out  = (mode_reg == MODE_DILATION) ? (zeros == 0) : (zeros != points);
      res.out_row    = cr[CoordWidth-1:0];
      res.out_column = cc[CoordWidth-1:0];
      res.frame_last = (cr + 1 == h) && (cc + 1 == w);
      pixels_due.push_back(res);
   endfunction

   // Push one pixel at the current position; returns 1 when a result comes out.
   function bit shift_in(bit pix);
      int unsigned w, h, r, c;
      bit          top, mid, made;
      w    = eff_dim(width_reg, MaxWidthDefault);
      h    = eff_dim(height_reg, MaxHeightDefault);
      r    = row_pos;
      c    = col_pos;
      made = 0;
      // start of a row closes the last column of the row two above
      if (c == 0 && r >= 2 && r - 2 < h) begin
         morph_point(window[5:3], window[8:6], 3'b111, r - 2, w - 1);
         made = 1;
      end
      top           = upper_buf[c];
      mid           = middle_buf[c];
      upper_buf[c]  = mid;
      middle_buf[c] = pix;
      window        = {pix, mid, top, window[8:3]};
      if (c >= 1 && r >= 1 && r - 1 < h) begin
         morph_point(window[2:0], window[5:3], window[8:6], r - 1, c - 1);
         made = 1;
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = r + 1;
      end else begin
         col_pos = c + 1;
      end
      if (made && pending > 0) pending--;
      return made;
   endfunction

   function void accept_request(logic kind, bit pix);
      int unsigned h;
      h = eff_dim(height_reg, MaxHeightDefault);
      if (kind == REQ_PIXEL) begin
         if (row_pos >= h) restart();   // image done: this pixel opens a new one
         pending++;
         void'(shift_in(pix));
      end else if (row_pos >= h && pending != 0) begin
         // drain walks virtual background pixels, at most two per flush
         if (!shift_in(1'b1)) void'(shift_in(1'b1));
      end
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (pixels_due.size() == 0) begin
         $error("unexpected result pixel: row %0d column %0d", got.out_row, got.out_column);
         error_count++;
         return;
      end
      want = pixels_due.pop_front();
      if (got.pixel_out !== want.pixel_out) begin
         $error("pixel_out: expected %0b, actual %0b", want.pixel_out, got.pixel_out);
         error_count++;
      end
      if (got.out_row !== want.out_row) begin
         $error("out_row: expected %0d, actual %0d", want.out_row, got.out_row);
         error_count++;
      end
      if (got.out_column !== want.out_column) begin
         $error("out_column: expected %0d, actual %0d", want.out_column, got.out_column);
         error_count++;
      end
      if (got.frame_last !== want.frame_last) begin
         $error("frame_last: expected %0b, actual %0b", want.frame_last, got.frame_last);
         error_count++;
      end
   endfunction
endclass

module tb_top;

   localparam int SettleCycles = 8;     // covers the line-buffer read stage plus the 4-deep result queue
   localparam int TotalItems   = 1300;  // request transactions over the whole run
   localparam int QuietFrom    = 1000;  // no idling on either side past this many

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [ReqDataWidth-1:0]  req_tdata;
   logic                     req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CfgWidth-1:0]      csr_wdata;

   morph_scoreboard sb = new();
   bit              gaps_on;
   int unsigned     stall_left;
   int unsigned     items_sent;
   rsp_type         observed;

   binary_morphology_3x3_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop in case a handshake or the final drain never completes
   initial begin
      #1_000_000;
      $display("[binary_morphology_3x3_top] ERROR");
      $finish;
   end

   // Result side: random stall bursts of rsp_tready while gaps_on is set.
   initial begin
      rsp_tready <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Outputs are sampled mid-cycle, where they hold what the next edge will see.
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         observed.pixel_out  = rsp_tdata[0];
         observed.out_row    = rsp_tdata[10:1];
         observed.out_column = rsp_tdata[20:11];
         observed.frame_last = rsp_tlast;
         sb.check_result(observed);
      end
   end

   // One request transaction. Entered and left on a rising edge; the handshake
   // is judged at the falling edge before the accepting edge.
   task automatic send_req(logic kind, bit pix);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(ReqDataWidth - 1){1'b0}}, pix};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      sb.accept_request(kind, pix);
      items_sent++;
      @(posedge clock);
   endtask

   // Wait until every predicted pixel is out, then let any flush or pixel that
   // produced nothing clear the pipeline before registers change.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.pixels_due.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // sel bit i writes register index i: width, height, mode, shape
   task automatic write_regs(bit [3:0] sel, bit [CfgWidth-1:0] w_val,
                             bit [CfgWidth-1:0] h_val, bit [CfgWidth-1:0] mode_val,
                             bit [CfgWidth-1:0] shape_val);
      bit [CfgWidth-1:0] vals [4];
      vals = '{w_val, h_val, mode_val, shape_val};
      for (int i = 0; i < 4; i++) begin
         if (sel[i]) begin
            csr_we    <= 1'b1;
            csr_index <= csr_index_type'(i);
            csr_wdata <= vals[i];
            @(posedge clock);
            sb.write_reg(csr_index_type'(i), vals[i]);
         end
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      int unsigned       w, h, n, flushes, zero_pct, phase;
      bit [CfgWidth-1:0] w_val, h_val;
      bit [3:0]          sel;

      reset = 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= REQ_PIXEL;
      csr_we     <= 1'b0;
      csr_index  <= REG_IMAGE_WIDTH;
      csr_wdata  <= '0;
      gaps_on = 1'b1;
      items_sent = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // flush in the middle of the reset-default image: ignored
      send_req(REQ_FLUSH, 1'b0);
      settle();

      // 3x3 with a single foreground pixel in the center, default dilation/square;
      // four flushes drain it, the fifth finds nothing pending
      write_regs(4'b0011, CfgWidth'(3), CfgWidth'(3), '0, '0);
      for (int i = 0; i < 9; i++) send_req(REQ_PIXEL, i != 4);
      repeat (5) send_req(REQ_FLUSH, 1'b1);
      settle();

      // zero geometry acts as 1x1; mode/shape data carry junk upper bits.
      // The single drain flush has to walk two positions.
      write_regs(4'b1111, '0, '0, CfgWidth'(11'h7FF), CfgWidth'(11'h7FE));
      send_req(REQ_PIXEL, 1'b0);
      send_req(REQ_FLUSH, 1'b0);
      send_req(REQ_FLUSH, 1'b1);
      settle();

      // 2x1: mid-image flush ignored, then a pixel right after the image
      // completes starts a new one and drops what was pending
      write_regs(4'b1111, CfgWidth'(2), CfgWidth'(1), CfgWidth'(MODE_DILATION),
                 CfgWidth'(SHAPE_CROSS));
      send_req(REQ_PIXEL, 1'b0);
      send_req(REQ_FLUSH, 1'b0);
      send_req(REQ_PIXEL, 1'b1);
      send_req(REQ_PIXEL, 1'b0);
      send_req(REQ_PIXEL, 1'b0);
      send_req(REQ_FLUSH, 1'b1);
      send_req(REQ_FLUSH, 1'b0);

      // --- random ---
      // phases 0 and 1 write a width, then a height, above the maximum (acts as
      // 1024) and send a short run that stops mid-image; phase 2 on uses small
      // images. Some images are cut short or drained only in part, so the next
      // phase starts mid-image or mid-drain.
      phase = 0;
      while (phase < 2 || items_sent < TotalItems) begin
         settle();
         gaps_on = (items_sent < QuietFrom);
         if (phase == 0) begin
            sel   = 4'b1111;
            w_val = CfgWidth'(1500);
            h_val = CfgWidth'(1);
         end else if (phase == 1) begin
            sel   = 4'b1111;
            w_val = CfgWidth'(1);
            h_val = CfgWidth'(2047);
         end else begin
            sel   = 4'($urandom_range(0, 15));
            // first small image always replaces the tall geometry
            if (phase == 2 || $urandom_range(0, 3) != 0) sel[1:0] = 2'b11;
            w_val = ($urandom_range(0, 3) == 0) ? CfgWidth'($urandom_range(9, 32))
                                                : CfgWidth'($urandom_range(1, 8));
            h_val = ($urandom_range(0, 3) == 0) ? CfgWidth'($urandom_range(9, 16))
                                                : CfgWidth'($urandom_range(1, 8));
            if ($urandom_range(0, 15) == 0) w_val = '0;
            if ($urandom_range(0, 15) == 0) h_val = '0;
         end
         write_regs(sel, w_val, h_val, CfgWidth'($urandom_range(0, 2047)),
                    CfgWidth'($urandom_range(0, 2047)));

         w = sb.eff_dim(sb.width_reg, MaxWidthDefault);
         h = sb.eff_dim(sb.height_reg, MaxHeightDefault);
         n = w * h;
         if (phase < 2) n = 48;
         else if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
         case ($urandom_range(0, 2))
            0:       zero_pct = 5;
            1:       zero_pct = 50;
            default: zero_pct = 95;   // dense foreground so erosion yields zeros
         endcase

         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) send_req(REQ_FLUSH, 1'($urandom_range(0, 1)));
            send_req(REQ_PIXEL, $urandom_range(0, 99) >= zero_pct);
         end
         // a full drain takes width + 1 flushes, width in a one-row image; extras find nothing pending.
         // A run cut short gets only a few flushes.
         if (n < w * h) begin
            flushes = $urandom_range(0, 3);
         end else begin
            flushes = ($urandom_range(0, 4) == 0) ? $urandom_range(0, w)
                                                   : w + 1 + $urandom_range(0, 2);
         end
         repeat (flushes) send_req(REQ_FLUSH, 1'($urandom_range(0, 1)));

         phase++;
      end

      settle();
      if (sb.error_count == 0) begin
         $display("[binary_morphology_3x3_top] OK");
      end else begin
         $display("[binary_morphology_3x3_top] ERROR");
      end
      $finish;
   end

endmodule
